>>> hdl/masked_gf16_share_alu_macros.svh
// Assertion macros shared by the masked GF(16) share ALU.
`ifndef MASKED_GF16_SHARE_ALU_MACROS_SVH
`define MASKED_GF16_SHARE_ALU_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only outside reset.
`define GFSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gfsa assertion failed");
// Checked on every edge, reset included.
`define GFSA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gfsa assertion failed");
`else
`define GFSA_ASSERT(label, clk, rst, prop)
`define GFSA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/gfsa_pkg.sv
// Types, constants and GF(16) helpers for the masked GF(16) share ALU.
`default_nettype none
package gfsa_pkg;

   localparam logic [2:0] CMD_ENCODE  = 3'd0;
   localparam logic [2:0] CMD_DECODE  = 3'd1;
   localparam logic [2:0] CMD_COPY    = 3'd2;
   localparam logic [2:0] CMD_XOR     = 3'd3;
   localparam logic [2:0] CMD_XOR3    = 3'd4;
   localparam logic [2:0] CMD_AND     = 3'd5;
   localparam logic [2:0] CMD_NOT     = 3'd6;
   localparam logic [2:0] CMD_REFRESH = 3'd7;

   // Generator matrix: column for the value, column for the random.
   localparam logic [3:0] GEN_V0 = 4'he;
   localparam logic [3:0] GEN_R0 = 4'hf;
   localparam logic [3:0] GEN_V1 = 4'hb;
   localparam logic [3:0] GEN_R1 = 4'ha;
   localparam logic [3:0] GEN_V2 = 4'h6;
   localparam logic [3:0] GEN_R2 = 4'h7;

   // Decoding weights.
   localparam logic [3:0] DEC_W0 = 4'h9;
   localparam logic [3:0] DEC_W1 = 4'hc;
   localparam logic [3:0] DEC_W2 = 4'h4;

   // Vandermonde points and degree reduction weights.
   localparam logic [3:0] VAND_P1 = 4'h6;
   localparam logic [3:0] VAND_P2 = 4'h7;
   localparam logic [3:0] RED_RB0 = 4'h2;
   localparam logic [3:0] RED_U2  = 4'hc;
   localparam logic [3:0] RED_RB1 = 4'hd;

   localparam logic [3:0] GF_ONE  = 4'h1;
   localparam logic [3:0] GF_ZERO = 4'h0;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [11:0] op_a;
      logic [11:0] op_b;
      logic [11:0] op_c;
      logic [3:0]  plain_in;
      logic [3:0]  rand_a;
      logic [3:0]  rand_b;
   } req_type;

   typedef struct packed {
      logic [11:0] shares_out;
      logic [3:0]  plain_out;
   } rsp_type;

   // Front stage result: final answer, or share products for a multiply.
   typedef struct packed {
      logic        is_mul;
      logic [3:0]  rand_b;
      logic [11:0] shares;
      logic [3:0]  plain;
   } front_type;

   // Reduce stage result: final answer, or reduced coefficients.
   typedef struct packed {
      logic        is_mul;
      logic [11:0] shares;
      logic [3:0]  plain;
   } reduce_type;

   // Multiplication modulo x^4+x+1.
   function automatic logic [3:0] gf_mul(input logic [3:0] x, input logic [3:0] y);
      logic [3:0] acc;
      logic [3:0] p;
      acc = 4'h0;
      p   = x;
      for (int i = 0; i < 4; i++) begin
         if (y[i]) begin
            acc = acc ^ p;
         end
         p = {p[2:0], 1'b0} ^ (p[3] ? 4'h3 : 4'h0);
      end
      return acc;
   endfunction

   // Share triple of value v with randomness r, share 0 in the low nibble.
   function automatic logic [11:0] gf_encode(input logic [3:0] v, input logic [3:0] r);
      logic [3:0] s0;
      logic [3:0] s1;
      logic [3:0] s2;
      s0 = gf_mul(GEN_V0, v) ^ gf_mul(GEN_R0, r);
      s1 = gf_mul(GEN_V1, v) ^ gf_mul(GEN_R1, r);
      s2 = gf_mul(GEN_V2, v) ^ gf_mul(GEN_R2, r);
      return {s2, s1, s0};
   endfunction

endpackage
`default_nettype wire

>>> hdl/masked_gf16_share_alu.sv
// Top level of the masked GF(16) share ALU: three-stage pipeline and flow control.
// An accepted beat moves through the stage one, two and three registers, and
// rsp_valid is the stage three valid bit.
// Throughput: one beat per cycle unless stalled; each stage register holds a beat.
// A stalled output backs up stage by stage, so empty stages still fill up.
// Reset clears the three stage valid bits; the data registers are not reset.
`default_nettype none
`include "masked_gf16_share_alu_macros.svh"
module masked_gf16_share_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire gfsa_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output gfsa_pkg::rsp_type        rsp_data
);
   import gfsa_pkg::*;

   // Per-stage valid bits and data registers.
   logic       s1_valid;
   logic       s2_valid;
   logic       s3_valid;
   front_type  s1_data;
   reduce_type s2_data;

   // Stage enables. A stage may load when it is empty or when the stage
   // after it is loading in the same cycle, so bubbles are squeezed out
   // and a stall never drops or repeats a beat.
   logic en1;
   logic en2;
   logic en3;

   assign en3 = !s3_valid || !rsp_stall;
   assign en2 = !s2_valid || en3;
   assign en1 = !s1_valid || en2;

   // The input side is held off only when the whole pipe is full and the
   // output beat is not being taken.
   assign req_stall = !en1;

   // Stage one handles every linear command and the decode, and forms the
   // share-wise products plus a fresh zero encoding for a masked multiply.
   gfsa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en1),
      .in_valid (req_valid),
      .in_data  (req_data),
      .valid_ff (s1_valid),
      .data_ff  (s1_data)
   );

   // Stage two applies the inverse transform and the degree reduction to a product.
   gfsa_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .en       (en2),
      .in_valid (s1_valid),
      .in_data  (s1_data),
      .valid_ff (s2_valid),
      .data_ff  (s2_data)
   );

   // Stage three re-encodes a product and is the output register.
   gfsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en3),
      .in_valid (s2_valid),
      .in_data  (s2_data),
      .valid_ff (s3_valid),
      .data_ff  (rsp_data)
   );

   assign rsp_valid = s3_valid;

   // Reset leaves no beat on the output.
   `GFSA_ASSERT_ALWAYS(a_reset_clears_out, clock, reset |=> !rsp_valid)
   // A full pipe with a stalled output must hold off the input.
   `GFSA_ASSERT(a_full_stalls_in, clock, reset,
      (s1_valid && s2_valid && s3_valid && rsp_stall) |-> req_stall)
   // An accepted beat always lands in stage one.
   `GFSA_ASSERT(a_accept_fills_s1, clock, reset, (req_valid && !req_stall) |=> s1_valid)
   // A beat held in stage two keeps its contents while it waits.
   `GFSA_ASSERT(a_s2_holds, clock, reset,
      (s2_valid && !en2) |=> (s2_valid && $stable(s2_data)))
   // Only a decode yields a plain value, and a decode yields no shares.
   `GFSA_ASSERT(a_decode_no_shares, clock, reset,
      (rsp_valid && (rsp_data.plain_out != 4'h0)) |-> (rsp_data.shares_out == 12'h000))

endmodule
`default_nettype wire

>>> hdl/gfsa_front.sv
// First pipeline stage: linear commands, decode and share-wise products.
`default_nettype none
module gfsa_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire gfsa_pkg::req_type   in_data,
   output logic                     valid_ff,
   output gfsa_pkg::front_type      data_ff
);
   import gfsa_pkg::*;

   front_type  data_in;
   logic [11:0] zero_enc;
   logic [11:0] one_enc;
   logic [11:0] prod;

   assign zero_enc = gf_encode(GF_ZERO, in_data.rand_a);
   assign one_enc  = gf_encode(GF_ONE, in_data.rand_a);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[4*i +: 4] = gf_mul(in_data.op_a[4*i +: 4], in_data.op_b[4*i +: 4]);
      end
   end

   always_comb begin
      data_in.is_mul = 1'b0;
      data_in.rand_b = in_data.rand_b;
      data_in.shares = 12'h000;
      data_in.plain  = 4'h0;
      unique case (in_data.cmd)
         CMD_ENCODE:  data_in.shares = gf_encode(in_data.plain_in, in_data.rand_a);
         CMD_DECODE:  data_in.plain  = gf_mul(in_data.op_a[3:0], DEC_W0)
                                     ^ gf_mul(in_data.op_a[7:4], DEC_W1)
                                     ^ gf_mul(in_data.op_a[11:8], DEC_W2);
         CMD_COPY:    data_in.shares = in_data.op_a;
         CMD_XOR:     data_in.shares = in_data.op_a ^ in_data.op_b;
         CMD_XOR3:    data_in.shares = in_data.op_a ^ in_data.op_b ^ in_data.op_c;
         CMD_AND: begin
            data_in.is_mul = 1'b1;
            data_in.shares = prod ^ zero_enc;
         end
         CMD_NOT:     data_in.shares = in_data.op_a ^ one_enc;
         CMD_REFRESH: data_in.shares = in_data.op_a ^ zero_enc;
         default:     data_in.shares = 12'h000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/gfsa_reduce.sv
// Second pipeline stage: inverse Vandermonde transform and degree reduction of a product.
`default_nettype none
module gfsa_reduce (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire gfsa_pkg::front_type   in_data,
   output logic                       valid_ff,
   output gfsa_pkg::reduce_type       data_ff
);
   import gfsa_pkg::*;

   reduce_type data_in;
   logic [3:0] t0;
   logic [3:0] t1;
   logic [3:0] t2;
   logic [3:0] u0;
   logic [3:0] u1;
   logic [3:0] u2;
   logic [3:0] c0;
   logic [3:0] c1;

   assign t0 = in_data.shares[3:0];
   assign t1 = in_data.shares[7:4];
   assign t2 = in_data.shares[11:8];

   assign u0 = t0 ^ t1 ^ t2;
   assign u1 = t0 ^ gf_mul(t1, VAND_P2) ^ gf_mul(t2, VAND_P1);
   assign u2 = t0 ^ gf_mul(t1, VAND_P1) ^ gf_mul(t2, VAND_P2);

   // The degree-two coefficient is folded away with the fresh random.
   assign c0 = u0 ^ gf_mul(in_data.rand_b, RED_RB0) ^ gf_mul(u2, RED_U2);
   assign c1 = u1 ^ gf_mul(in_data.rand_b, RED_RB1);

   always_comb begin
      data_in.is_mul = in_data.is_mul;
      data_in.plain  = in_data.plain;
      if (in_data.is_mul) begin
         data_in.shares = {GF_ZERO, c1, c0};
      end else begin
         data_in.shares = in_data.shares;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/gfsa_back.sv
// Third pipeline stage: forward Vandermonde transform of a product into the output register.
`default_nettype none
module gfsa_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire gfsa_pkg::reduce_type   in_data,
   output logic                        valid_ff,
   output gfsa_pkg::rsp_type           data_ff
);
   import gfsa_pkg::*;

   rsp_type    data_in;
   logic [3:0] t0;
   logic [3:0] t1;
   logic [3:0] t2;
   logic [11:0] fwd;

   assign t0 = in_data.shares[3:0];
   assign t1 = in_data.shares[7:4];
   assign t2 = in_data.shares[11:8];

   assign fwd[3:0]  = t0 ^ t1 ^ t2;
   assign fwd[7:4]  = t0 ^ gf_mul(t1, VAND_P1) ^ gf_mul(t2, VAND_P2);
   assign fwd[11:8] = t0 ^ gf_mul(t1, VAND_P2) ^ gf_mul(t2, VAND_P1);

   always_comb begin
      data_in.plain_out  = in_data.plain;
      data_in.shares_out = in_data.is_mul ? fwd : in_data.shares;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire
